### src/tuner_rf_register_program_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tuner RF register program block
// Concurrent assertion wrappers clocked on a named clock and reset.
// ---------------------------------------------------------------------------
`ifndef TUNER_RF_REGISTER_PROGRAM_TOP_ASSERT_SVH
`define TUNER_RF_REGISTER_PROGRAM_TOP_ASSERT_SVH

// check a property on a given clock, off while reset is low
`define TRP_ASSERT_ON(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on clk and arst_n
`define TRP_ASSERT(lbl, prop, msg) \
	`TRP_ASSERT_ON(lbl, clk, arst_n, prop, msg)

`endif

### src/trp_pkg.sv
// ---------------------------------------------------------------------------
// Tuner RF register program package
// Field widths, register addresses, fixed values and shared types.
// ---------------------------------------------------------------------------
package trp_pkg;

	localparam int unsigned FREQ_W   = 30;
	localparam int unsigned BW_W     = 2;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned QUOT_W   = 11;
	localparam int unsigned REM_W    = 20;
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned FRAC_W   = 6;

	localparam logic [REM_W-1:0] HZ_PER_MHZ   = 20'd1000000;
	localparam logic [REM_W-1:0] CENTER_LIMIT = 20'd7812;

	// floor(2^40 / 1e6): quotient estimate is low by at most one
	localparam logic [20:0]      RECIP_MHZ   = 21'd1099511;
	localparam int unsigned      RECIP_SHIFT = 40;
	localparam int unsigned      PROD_W      = FREQ_W + 21;

	localparam logic [FREQ_W-1:0] BAND_LOW_LIMIT = 30'd444000000;
	localparam logic [FREQ_W-1:0] BAND_MID_LIMIT = 30'd667000000;
	localparam logic [FREQ_W-1:0] LOWBAND_LIMIT  = 30'd334000000;

	localparam logic [BYTE_W-1:0] ADDR_ABORT   = 8'h10;
	localparam logic [BYTE_W-1:0] ADDR_BW      = 8'h0D;
	localparam logic [BYTE_W-1:0] ADDR_FREQ_LO = 8'h0E;
	localparam logic [BYTE_W-1:0] ADDR_FREQ_HI = 8'h0F;
	localparam logic [BYTE_W-1:0] ADDR_BAND    = 8'hAB;
	localparam logic [BYTE_W-1:0] ADDR_LOWBAND = 8'h91;

	localparam logic [BYTE_W-1:0] VAL_ABORT    = 8'h00;
	localparam logic [BYTE_W-1:0] BAND_LOW     = 8'h70;
	localparam logic [BYTE_W-1:0] BAND_MID     = 8'h20;
	localparam logic [BYTE_W-1:0] BAND_HIGH    = 8'h10;
	localparam logic [BYTE_W-1:0] LOWBAND_ON   = 8'h40;
	localparam logic [BYTE_W-1:0] LOWBAND_OFF  = 8'h00;

	typedef enum logic [BW_W-1:0] {
		BW_6MHZ    = 2'd0,
		BW_7MHZ    = 2'd1,
		BW_8MHZ    = 2'd2,
		BW_INVALID = 2'd3
	} bw_code_t;

	typedef enum logic [2:0] {
		PAIR_ABORT,
		PAIR_BW,
		PAIR_FREQ_LO,
		PAIR_FREQ_HI,
		PAIR_BAND,
		PAIR_LOWBAND
	} pair_t;

	typedef struct packed {
		logic [QUOT_W-1:0] mhz;
		logic [REM_W-1:0]  rem;
		logic [BYTE_W-1:0] band;
		logic              lowband;
		logic [BW_W-1:0]   bw;
	} item_t;

	function automatic logic [BYTE_W-1:0] bw_byte(input logic [BW_W-1:0] code);
		logic [BYTE_W-1:0] b;
		case (code)
			BW_6MHZ: b = 8'h49;
			BW_7MHZ: b = 8'h5A;
			BW_8MHZ: b = 8'h6F;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

### src/trp_req_if.sv
// ---------------------------------------------------------------------------
// Tune request channel
// Valid/ready channel carrying RF frequency and bandwidth code.
// ---------------------------------------------------------------------------
interface trp_req_if;
	logic                         valid;
	logic                         ready;
	logic [trp_pkg::FREQ_W-1:0]   rf_freq_hz;
	logic [trp_pkg::BW_W-1:0]     bandwidth_code;

	modport source (output valid, output rf_freq_hz, output bandwidth_code, input ready);
	modport sink (input valid, input rf_freq_hz, input bandwidth_code, output ready);
endinterface

### src/trp_rsp_if.sv
// ---------------------------------------------------------------------------
// Register pair channel
// Valid/ready channel carrying one register address/value pair.
// ---------------------------------------------------------------------------
interface trp_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [trp_pkg::BYTE_W-1:0]   reg_address;
	logic [trp_pkg::BYTE_W-1:0]   reg_value;
	logic                         last_pair;
	logic                         error_status;

	modport source (output valid, output reg_address, output reg_value, output last_pair,
		output error_status, input ready);
	modport sink (input valid, input reg_address, input reg_value, input last_pair,
		input error_status, output ready);
endinterface

### src/trp_pair_seq.sv
// ---------------------------------------------------------------------------
// Register pair sequencer
// Finishes the tuning word and emits the six address/value pairs in order, or one zero pair on a bad bandwidth code.
// ---------------------------------------------------------------------------
module trp_pair_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  trp_pkg::item_t      item,
	output logic                item_ready,
	trp_rsp_if.source           rsp
);

	logic [trp_pkg::WORD_W-1:0] word_d;
	logic [trp_pkg::WORD_W-1:0] word_q;
	logic [trp_pkg::BYTE_W-1:0] band_q;
	logic                       lowband_q;
	logic [trp_pkg::BW_W-1:0]   bw_q;
	logic                       err_q;
	logic                       valid_q;
	trp_pkg::pair_t             pair_q;
	logic                       last;

	always_comb begin
		logic [trp_pkg::REM_W-1:0]  r;
		logic [trp_pkg::REM_W-1:0]  step;
		logic [trp_pkg::FRAC_W-1:0] frac;
		logic                       inc;
		r    = item.rem;
		step = trp_pkg::HZ_PER_MHZ;
		frac = '0;
		for (int i = 0; i < trp_pkg::FRAC_W; i++) begin
			step = step >> 1;
			if (r > step) begin
				r    = r - step;
				frac = {frac[trp_pkg::FRAC_W-2:0], 1'b1};
			end else begin
				frac = {frac[trp_pkg::FRAC_W-2:0], 1'b0};
			end
		end
		inc    = (r > trp_pkg::CENTER_LIMIT);
		word_d = {item.mhz[trp_pkg::WORD_W-trp_pkg::FRAC_W-1:0], frac}
			+ trp_pkg::WORD_W'(inc);
	end

	assign last       = err_q || (pair_q == trp_pkg::PAIR_LOWBAND);
	assign item_ready = !valid_q || (rsp.ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pair_q  <= trp_pkg::PAIR_ABORT;
		end else if (item_ready) begin
			valid_q <= item_valid;
			pair_q  <= trp_pkg::PAIR_ABORT;
		end else if (rsp.ready) begin
			pair_q  <= trp_pkg::pair_t'(pair_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			word_q    <= word_d;
			band_q    <= item.band;
			lowband_q <= item.lowband;
			bw_q      <= item.bw;
			err_q     <= (item.bw == trp_pkg::BW_INVALID);
		end
	end

	always_comb begin
		rsp.valid        = valid_q;
		rsp.last_pair    = last;
		rsp.error_status = err_q;
		rsp.reg_address  = '0;
		rsp.reg_value    = '0;
		if (!err_q) begin
			case (pair_q)
				trp_pkg::PAIR_ABORT: begin
					rsp.reg_address = trp_pkg::ADDR_ABORT;
					rsp.reg_value   = trp_pkg::VAL_ABORT;
				end
				trp_pkg::PAIR_BW: begin
					rsp.reg_address = trp_pkg::ADDR_BW;
					rsp.reg_value   = trp_pkg::bw_byte(bw_q);
				end
				trp_pkg::PAIR_FREQ_LO: begin
					rsp.reg_address = trp_pkg::ADDR_FREQ_LO;
					rsp.reg_value   = word_q[7:0];
				end
				trp_pkg::PAIR_FREQ_HI: begin
					rsp.reg_address = trp_pkg::ADDR_FREQ_HI;
					rsp.reg_value   = word_q[15:8];
				end
				trp_pkg::PAIR_BAND: begin
					rsp.reg_address = trp_pkg::ADDR_BAND;
					rsp.reg_value   = band_q;
				end
				trp_pkg::PAIR_LOWBAND: begin
					rsp.reg_address = trp_pkg::ADDR_LOWBAND;
					rsp.reg_value   = lowband_q ? trp_pkg::LOWBAND_ON : trp_pkg::LOWBAND_OFF;
				end
				default: begin
					rsp.reg_address = '0;
					rsp.reg_value   = '0;
				end
			endcase
		end
	end

endmodule

### src/tuner_rf_register_program_top.sv
// A request is registered in s1-s4 and u_seq before its first pair on rsp.
// Throughput: one pair per cycle while rsp.ready is high; a valid request
// gives six pairs, an invalid bandwidth code one, paced by the single-pair
// output port. Four pipeline stages ahead of the sequencer keep taking
// requests while pairs drain. Reset clears all valid flags and pair index.
// ---------------------------------------------------------------------------
// Tuner RF register program top level
// Converts frequency to MHz and remainder by reciprocal multiply, then
// sequences the register pairs.
// ---------------------------------------------------------------------------
module tuner_rf_register_program_top (
	input  logic      clk,
	input  logic      arst_n,
	trp_req_if.sink   req,
	trp_rsp_if.source rsp
);

	logic                          v_s1, v_s2, v_s3, v_s4;
	logic                          rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic                          seq_ready;

	logic [trp_pkg::FREQ_W-1:0]    freq_s1, freq_s2, freq_s3;
	logic [trp_pkg::BW_W-1:0]      bw_s1, bw_s2, bw_s3;
	logic [trp_pkg::QUOT_W-1:0]    qest_s2, qest_s3;
	logic [trp_pkg::FREQ_W-1:0]    qm_s3;
	trp_pkg::item_t                item_s4;

	logic [trp_pkg::PROD_W-1:0]    prod;
	logic [trp_pkg::FREQ_W:0]      qm_full;
	logic [trp_pkg::REM_W:0]       rem_raw;
	logic                          rem_over;
	trp_pkg::item_t                item_d;

	assign rdy_s4    = !v_s4 || seq_ready;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign req.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= req.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	assign prod    = trp_pkg::PROD_W'(freq_s1) * trp_pkg::PROD_W'(trp_pkg::RECIP_MHZ);
	assign qm_full = (trp_pkg::FREQ_W + 1)'(qest_s2)
		* (trp_pkg::FREQ_W + 1)'(trp_pkg::HZ_PER_MHZ);
	assign rem_raw = freq_s3[trp_pkg::REM_W:0] - qm_s3[trp_pkg::REM_W:0];
	assign rem_over = (rem_raw >= (trp_pkg::REM_W + 1)'(trp_pkg::HZ_PER_MHZ));

	always_comb begin
		item_d.mhz = rem_over ? qest_s3 + trp_pkg::QUOT_W'(1) : qest_s3;
		item_d.rem = rem_over
			? trp_pkg::REM_W'(rem_raw - (trp_pkg::REM_W + 1)'(trp_pkg::HZ_PER_MHZ))
			: rem_raw[trp_pkg::REM_W-1:0];
		if (freq_s3 < trp_pkg::BAND_LOW_LIMIT)
			item_d.band = trp_pkg::BAND_LOW;
		else if (freq_s3 < trp_pkg::BAND_MID_LIMIT)
			item_d.band = trp_pkg::BAND_MID;
		else
			item_d.band = trp_pkg::BAND_HIGH;
		item_d.lowband = (freq_s3 <= trp_pkg::LOWBAND_LIMIT);
		item_d.bw      = bw_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			freq_s1 <= req.rf_freq_hz;
			bw_s1   <= req.bandwidth_code;
		end
		if (rdy_s2) begin
			freq_s2 <= freq_s1;
			bw_s2   <= bw_s1;
			qest_s2 <= prod[trp_pkg::RECIP_SHIFT +: trp_pkg::QUOT_W];
		end
		if (rdy_s3) begin
			freq_s3 <= freq_s2;
			bw_s3   <= bw_s2;
			qest_s3 <= qest_s2;
			qm_s3   <= qm_full[trp_pkg::FREQ_W-1:0];
		end
		if (rdy_s4) begin
			item_s4 <= item_d;
		end
	end

	trp_pair_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (v_s4),
		.item       (item_s4),
		.item_ready (seq_ready),
		.rsp        (rsp)
	);

endmodule

### src/trp_checker.sv
// ---------------------------------------------------------------------------
// Tuner RF register program checker
// Port-level checks on the pair stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "tuner_rf_register_program_top_assert.svh"

module trp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [trp_pkg::BYTE_W-1:0] reg_address,
	input logic [trp_pkg::BYTE_W-1:0] reg_value,
	input logic                       last_pair,
	input logic                       error_status
);

	`TRP_ASSERT(a_err_alone, rsp_valid && error_status |-> last_pair && reg_address == 8'd0 && reg_value == 8'd0, "error result not a lone zero pair")
	`TRP_ASSERT(a_run_gapless, rsp_valid && rsp_ready && !last_pair |=> rsp_valid, "gap inside a pair run")
	`TRP_ASSERT(a_last_is_lowband, rsp_valid && !error_status |-> last_pair == (reg_address == trp_pkg::ADDR_LOWBAND), "last flag not on the low-band pair")
	`TRP_ASSERT(a_freq_order, rsp_valid && rsp_ready && !error_status && reg_address == trp_pkg::ADDR_FREQ_LO |=> rsp_valid && reg_address == trp_pkg::ADDR_FREQ_HI, "high frequency byte does not follow low byte")
	`TRP_ASSERT(a_hold_stalled, rsp_valid && !rsp_ready |=> rsp_valid && $stable(reg_address) && $stable(reg_value), "stalled pair changed")

endmodule

bind tuner_rf_register_program_top trp_checker u_trp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.reg_address  (rsp.reg_address),
	.reg_value    (rsp.reg_value),
	.last_pair    (rsp.last_pair),
	.error_status (rsp.error_status)
);
